[design/crce_pkg.sv]
// Package with the item types, codes and constants of the Catmull-Rom curve evaluator.
`timescale 1ns / 1ps
package crce_pkg;

  // Item codes.
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_EVAL   = 1'b1;

  localparam logic [1:0] ST_POINT = 2'd0;
  localparam logic [1:0] ST_STORED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_FEW = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic signed [31:0] knot_z;
    logic signed [23:0] ratio;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [1:0]         status;
  } out_item_t;

  // Command kinds passed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_KNOT   = 2'd1,
    CMD_CURVE  = 2'd2
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_COEF,
    BK_HORNER,
    BK_FINISH,
    BK_OUT
  } back_state_e;

  // Saturate a wide signed value into 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[design/crce_front.sv]
// Front part: accepts items, keeps the knot count and classifies each item into a command.
`timescale 1ns / 1ps
module crce_front #(
  parameter int unsigned MaxKnots = 64,
  parameter int unsigned CntW = $clog2(MaxKnots + 1),
  parameter int unsigned IdxW = $clog2(MaxKnots)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crce_pkg::in_item_t  in_item_i,
  input  logic                loop_mode_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output crce_pkg::cmd_kind_e cmd_kind_o,
  output logic [1:0]          cmd_status_o,
  output logic [IdxW-1:0]     cmd_idx_o,
  output logic [CntW-1:0]     cmd_cnt_o,
  output logic [15:0]         cmd_r_o,
  output logic                cmd_end_o,
  output logic                cmd_loop_o,
  output logic [95:0]         cmd_knot_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            acc;
  logic            full;

  assign in_stall_o = !cmd_ready_i;
  assign acc = in_valid_i && cmd_ready_i;
  assign full = (cnt_q == CntW'(MaxKnots));

  // Classify the item.
  always_comb begin
    cnt_d        = cnt_q;
    cmd_kind_o   = crce_pkg::CMD_REPORT;
    cmd_status_o = crce_pkg::ST_STORED;
    cmd_idx_o    = cnt_q[IdxW-1:0];
    cmd_cnt_o    = cnt_q;
    cmd_r_o      = in_item_i.ratio[15:0];
    cmd_end_o    = 1'b0;
    cmd_loop_o   = loop_mode_i;
    cmd_knot_o   = {in_item_i.knot_x, in_item_i.knot_y, in_item_i.knot_z};
    if (in_item_i.action == crce_pkg::ACT_APPEND) begin
      if (full) begin
        cmd_status_o = crce_pkg::ST_FULL;
      end else begin
        cmd_kind_o = crce_pkg::CMD_KNOT;
        if (acc) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end else if (cnt_q < CntW'(4)) begin
      cmd_status_o = crce_pkg::ST_FEW;
    end else begin
      cmd_kind_o   = crce_pkg::CMD_CURVE;
      cmd_status_o = crce_pkg::ST_POINT;
      if (!loop_mode_i) begin
        if (in_item_i.ratio[23]) begin
          cmd_r_o = '0;
        end else if (in_item_i.ratio[22:16] != '0) begin
          cmd_end_o = 1'b1;
        end
      end
    end
  end

  assign cmd_valid_o = in_valid_i;

  // Knot count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[design/crce_queue.sv]
// Short command queue between the front part and the back part.
`timescale 1ns / 1ps
module crce_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [2];
  logic [1:0]       cnt_q;
  logic             wp_q, rp_q;
  logic             wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (wr) begin
        wp_q <= !wp_q;
      end
      if (rd) begin
        rp_q <= !rp_q;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Entries.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

[design/crce_back.sv]
// Back part: knot memory, segment search and Horner evaluation shared over three axes.
`timescale 1ns / 1ps
module crce_back #(
  parameter int unsigned MaxKnots = 64,
  parameter int unsigned CntW = $clog2(MaxKnots + 1),
  parameter int unsigned IdxW = $clog2(MaxKnots)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  crce_pkg::cmd_kind_e cmd_kind_i,
  input  logic [1:0]          cmd_status_i,
  input  logic [IdxW-1:0]     cmd_idx_i,
  input  logic [CntW-1:0]     cmd_cnt_i,
  input  logic [15:0]         cmd_r_i,
  input  logic                cmd_end_i,
  input  logic                cmd_loop_i,
  input  logic [95:0]         cmd_knot_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crce_pkg::out_item_t out_item_o
);

  crce_pkg::back_state_e st_q, st_d;

  logic [95:0] mem [MaxKnots];
  logic [95:0] rd_q;
  logic [IdxW-1:0] ra;

  logic [CntW-1:0]  n_q;
  logic [CntW-1:0]  seg_q;
  logic [15:0]      t_q;
  logic [2:0]       k_q;        // knot read counter
  logic [1:0]       ax_q;       // axis counter
  logic [1:0]       hs_q;       // Horner step
  logic             end_q;
  logic signed [31:0] p_q [4][3];
  logic signed [39:0] c1_q, c2_q, c3_q, p1x2_q, acc_q;
  logic signed [31:0] res_q [3];
  logic [1:0]       stat_q;
  logic             ov_q;
  logic [IdxW-1:0]  idx_base;
  logic [CntW:0]    idx_sum;

  // Product of ratio and segment count.
  logic [CntW+15:0] prod;
  logic [CntW-1:0]  segs;

  assign segs = cmd_loop_i ? cmd_cnt_i : (cmd_cnt_i - CntW'(3));
  assign prod = (CntW + 16)'(cmd_r_i) * (CntW + 16)'(segs);

  assign cmd_ready_o = (st_q == crce_pkg::BK_IDLE) && !ov_q;

  // Knot read address: end of an open curve reads knot N-2, otherwise seg+k mod N.
  always_comb begin
    idx_sum = (CntW + 1)'(seg_q) + (CntW + 1)'(k_q);
    if (idx_sum >= (CntW + 1)'(n_q)) begin
      idx_sum = idx_sum - (CntW + 1)'(n_q);
    end
    idx_base = idx_sum[IdxW-1:0];
    if (end_q) begin
      ra = IdxW'(n_q - CntW'(2));
    end else begin
      ra = idx_base;
    end
  end

  // Knot memory.
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o && cmd_kind_i == crce_pkg::CMD_KNOT) begin
      mem[cmd_idx_i] <= cmd_knot_i;
    end
    rd_q <= mem[ra];
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      crce_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          st_d = (cmd_kind_i == crce_pkg::CMD_CURVE) ? crce_pkg::BK_READ : crce_pkg::BK_OUT;
        end
      end
      crce_pkg::BK_READ: begin
        if (end_q && k_q == 3'd1) begin
          st_d = crce_pkg::BK_OUT;
        end else if (k_q == 3'd4) begin
          st_d = crce_pkg::BK_COEF;
        end
      end
      crce_pkg::BK_COEF:   st_d = crce_pkg::BK_HORNER;
      crce_pkg::BK_HORNER: if (hs_q == 2'd2) st_d = crce_pkg::BK_FINISH;
      crce_pkg::BK_FINISH: st_d = (ax_q == 2'd2) ? crce_pkg::BK_OUT : crce_pkg::BK_COEF;
      crce_pkg::BK_OUT:    st_d = crce_pkg::BK_IDLE;
      default:             st_d = crce_pkg::BK_IDLE;
    endcase
  end

  // Datapath for the current axis.
  logic signed [31:0] a0, a1, a2, a3;
  logic signed [39:0] hmul_src;
  logic signed [56:0] hprod;
  logic signed [39:0] hnext;
  logic signed [39:0] fin;

  always_comb begin
    a0 = p_q[0][ax_q];
    a1 = p_q[1][ax_q];
    a2 = p_q[2][ax_q];
    a3 = p_q[3][ax_q];
    hmul_src = acc_q;
    hprod = 57'(hmul_src) * $signed({1'b0, t_q});
    hnext = 40'(hprod >>> 16);
    case (hs_q)
      2'd0:    hnext = hnext + c2_q;
      2'd1:    hnext = hnext + c1_q;
      default: hnext = hnext + p1x2_q;
    endcase
    fin = (acc_q + 40'sd1) >>> 1;
  end

  // Outputs of each state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= crce_pkg::BK_IDLE;
      ov_q  <= 1'b0;
      k_q   <= '0;
      ax_q  <= '0;
      hs_q  <= '0;
    end else begin
      st_q <= st_d;
      if (out_valid_o && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        crce_pkg::BK_IDLE: begin
          k_q  <= '0;
          ax_q <= '0;
          hs_q <= '0;
        end
        crce_pkg::BK_READ: begin
          k_q <= k_q + 3'd1;
        end
        crce_pkg::BK_HORNER: begin
          hs_q <= hs_q + 2'd1;
        end
        crce_pkg::BK_FINISH: begin
          ax_q <= ax_q + 2'd1;
          hs_q <= '0;
        end
        crce_pkg::BK_OUT: begin
          ov_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers. A new command is taken only on acceptance, so a waiting
  // result stays unchanged.
  always_ff @(posedge clk_i) begin
    case (st_q)
      crce_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          n_q    <= cmd_cnt_i;
          seg_q  <= prod[CntW+15:16];
          t_q    <= prod[15:0];
          end_q  <= cmd_end_i;
          stat_q <= cmd_status_i;
          for (int a = 0; a < 3; a++) begin
            res_q[a] <= '0;
          end
        end
      end
      crce_pkg::BK_READ: begin
        if (k_q != 3'd0) begin
          p_q[k_q[1:0] - 2'd1][0] <= rd_q[95:64];
          p_q[k_q[1:0] - 2'd1][1] <= rd_q[63:32];
          p_q[k_q[1:0] - 2'd1][2] <= rd_q[31:0];
          if (end_q) begin
            res_q[0] <= rd_q[95:64];
            res_q[1] <= rd_q[63:32];
            res_q[2] <= rd_q[31:0];
          end
        end
      end
      crce_pkg::BK_COEF: begin
        c1_q   <= 40'(a2) - 40'(a0);
        c2_q   <= 40'(a0) * 40'sd2 - 40'(a1) * 40'sd5 + 40'(a2) * 40'sd4 - 40'(a3);
        c3_q   <= 40'(a1) * 40'sd3 - 40'(a0) - 40'(a2) * 40'sd3 + 40'(a3);
        acc_q  <= 40'(a1) * 40'sd3 - 40'(a0) - 40'(a2) * 40'sd3 + 40'(a3);
        p1x2_q <= 40'(a1) * 40'sd2;
      end
      crce_pkg::BK_HORNER: begin
        acc_q <= hnext;
      end
      crce_pkg::BK_FINISH: begin
        res_q[ax_q] <= crce_pkg::sat32(fin);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_item_o.pos_x = res_q[0];
  assign out_item_o.pos_y = res_q[1];
  assign out_item_o.pos_z = res_q[2];
  assign out_item_o.status = stat_q;

endmodule

[design/catmull_rom_curve_evaluator.sv]
// Top level of the Catmull-Rom curve evaluator.
`timescale 1ns / 1ps
// Keeps up to MAX_KNOTS knots in a memory and evaluates a uniform Catmull-Rom
// curve through them. An evaluate item reads four knots one per cycle from the
// single memory port, then runs coefficient setup and three Horner steps for
// each axis on one shared 40x17 multiplier. An open-curve ratio of one or more
// reads only knot N-2 and returns it, and an append or a status-only item goes
// straight to the output state. The back part takes no new item until its
// result has been taken, so output stalls hold it. A two-entry queue lets the
// input run up to two items ahead of the back part.
// loop_mode is written through its own valid/ready port.
module catmull_rom_curve_evaluator #(
  parameter int unsigned MAX_KNOTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crce_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crce_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_KNOTS + 1);
  localparam int unsigned IdxW = $clog2(MAX_KNOTS);
  localparam int unsigned QW = 2 + 2 + IdxW + CntW + 16 + 1 + 1 + 96;

  logic loop_q;
  logic                f_valid, f_ready;
  crce_pkg::cmd_kind_e f_kind;
  logic [1:0]          f_status;
  logic [IdxW-1:0]     f_idx;
  logic [CntW-1:0]     f_cnt;
  logic [15:0]         f_r;
  logic                f_end, f_loop;
  logic [95:0]         f_knot;
  logic [QW-1:0]       q_in, q_out;
  logic                b_valid, b_ready;

  assign cfg_ready_o = 1'b1;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q <= 1'b0;
    end else if (cfg_valid_i) begin
      loop_q <= cfg_data_i;
    end
  end

  crce_front #(.MaxKnots(MAX_KNOTS), .CntW(CntW), .IdxW(IdxW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .loop_mode_i(loop_q), .cmd_valid_o(f_valid), .cmd_ready_i(f_ready),
    .cmd_kind_o(f_kind), .cmd_status_o(f_status), .cmd_idx_o(f_idx),
    .cmd_cnt_o(f_cnt), .cmd_r_o(f_r), .cmd_end_o(f_end), .cmd_loop_o(f_loop),
    .cmd_knot_o(f_knot)
  );

  assign q_in = {f_kind, f_status, f_idx, f_cnt, f_r, f_end, f_loop, f_knot};

  crce_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(q_in),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(q_out)
  );

  crce_back #(.MaxKnots(MAX_KNOTS), .CntW(CntW), .IdxW(IdxW)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_ready_o(b_ready),
    .cmd_kind_i(crce_pkg::cmd_kind_e'(q_out[QW-1 -: 2])),
    .cmd_status_i(q_out[QW-3 -: 2]),
    .cmd_idx_i(q_out[QW-5 -: IdxW]),
    .cmd_cnt_i(q_out[QW-5-IdxW -: CntW]),
    .cmd_r_i(q_out[QW-5-IdxW-CntW -: 16]),
    .cmd_end_i(q_out[97]), .cmd_loop_i(q_out[96]), .cmd_knot_i(q_out[95:0]),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the Catmull-Rom curve evaluator.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned KNOT_CAP = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  crce_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  crce_pkg::out_item_t out_item_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  catmull_rom_curve_evaluator #(.MAX_KNOTS(KNOT_CAP)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Predictor state.
  logic signed [31:0] knots_q [KNOT_CAP][3];
  int unsigned knot_total;
  logic curve_closed;

  crce_pkg::in_item_t pending_items[$];
  crce_pkg::out_item_t expected_points[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit calm_phase;
  bit in_taken;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Floor division by a power of two on a signed value.
  function automatic longint floor_div(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] spline_axis(longint p0, longint p1, longint p2,
                                                     longint p3, longint t);
    longint c1, c2, c3, acc;
    c1 = -p0 + p2;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c3 = -p0 + 3 * p1 - 3 * p2 + p3;
    acc = c3;
    acc = floor_div(acc * t, 16) + c2;
    acc = floor_div(acc * t, 16) + c1;
    acc = floor_div(acc * t, 16) + 2 * p1;
    return clamp32(floor_div(acc + 1, 1));
  endfunction

  // Works out the result of one item and updates the knot table.
  function automatic crce_pkg::out_item_t predict_point(crce_pkg::in_item_t it);
    crce_pkg::out_item_t res;
    int unsigned segs, r, p, seg;
    int unsigned idx[4];
    longint t;
    res = '0;
    if (it.action == crce_pkg::ACT_APPEND) begin
      if (knot_total >= KNOT_CAP) begin
        res.status = crce_pkg::ST_FULL;
      end else begin
        knots_q[knot_total][0] = it.knot_x;
        knots_q[knot_total][1] = it.knot_y;
        knots_q[knot_total][2] = it.knot_z;
        knot_total++;
        res.status = crce_pkg::ST_STORED;
      end
      return res;
    end
    if (knot_total < 4) begin
      res.status = crce_pkg::ST_FEW;
      return res;
    end
    res.status = crce_pkg::ST_POINT;
    if (curve_closed) begin
      r = it.ratio[15:0];
      segs = knot_total;
    end else begin
      if (it.ratio >= 24'sd65536) begin
        res.pos_x = knots_q[knot_total-2][0];
        res.pos_y = knots_q[knot_total-2][1];
        res.pos_z = knots_q[knot_total-2][2];
        return res;
      end
      r = it.ratio[23] ? 0 : it.ratio;
      segs = knot_total - 3;
    end
    p = r * segs;
    seg = p >> 16;
    t = p & 32'hffff;
    for (int k = 0; k < 4; k++) idx[k] = (seg + k) % knot_total;
    res.pos_x = spline_axis(knots_q[idx[0]][0], knots_q[idx[1]][0],
                            knots_q[idx[2]][0], knots_q[idx[3]][0], t);
    res.pos_y = spline_axis(knots_q[idx[0]][1], knots_q[idx[1]][1],
                            knots_q[idx[2]][1], knots_q[idx[3]][1], t);
    res.pos_z = spline_axis(knots_q[idx[0]][2], knots_q[idx[1]][2],
                            knots_q[idx[2]][2], knots_q[idx[3]][2], t);
    return res;
  endfunction

  function automatic crce_pkg::in_item_t make_knot(logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
    crce_pkg::in_item_t it;
    it = '0;
    it.action = crce_pkg::ACT_APPEND;
    it.knot_x = x;
    it.knot_y = y;
    it.knot_z = z;
    it.ratio = 24'($urandom());
    return it;
  endfunction

  function automatic crce_pkg::in_item_t make_eval(logic signed [23:0] ratio);
    crce_pkg::in_item_t it;
    it = '0;
    it.action = crce_pkg::ACT_EVAL;
    it.knot_x = $urandom();
    it.knot_y = $urandom();
    it.knot_z = $urandom();
    it.ratio = ratio;
    return it;
  endfunction

  // Appends an item to the pending list.
  function automatic void add_item(crce_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Random knot coordinate: mostly moderate, sometimes extreme.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic logic signed [23:0] rand_ratio();
    case ($urandom_range(0, 7))
      0: return 24'($urandom());
      1: return 24'($urandom_range(65536, 65539));
      2: return -$signed({8'd0, 16'($urandom_range(0, 65535))});
      default: return 24'($urandom_range(0, 65535));
    endcase
  endfunction

  // Driver: presents queued items at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken || !in_valid_i) begin
        if (pending_items.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 11)) begin
          in_item_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= calm_phase ? 1'b0 : ($urandom_range(0, 99) < 11);
    end
  end

  // Monitor: predicts on accepted inputs, checks accepted results.
  always @(posedge clk_i) begin
    crce_pkg::out_item_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        expected_points.insert(expected_points.size(), predict_point(in_item_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item_o);
          error_count++;
        end else begin
          want = expected_points.pop_front();
          if (want.pos_x !== out_item_o.pos_x)
            $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, out_item_o.pos_x);
          if (want.pos_y !== out_item_o.pos_y)
            $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, out_item_o.pos_y);
          if (want.pos_z !== out_item_o.pos_z)
            $display("%0t: pos_z expected %h actual %h", $time, want.pos_z, out_item_o.pos_z);
          if (want.status !== out_item_o.status)
            $display("%0t: status expected %h actual %h", $time, want.status,
                     out_item_o.status);
          if (want !== out_item_o) error_count++;
        end
      end
    end
  end

  // Cycle limit watchdog.
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_points.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_mode(logic closed);
    @(negedge clk_i);
    cfg_data_i <= closed;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    curve_closed = closed;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase: mostly evaluations with knot appends mixed in at random.
  task automatic random_phase(int unsigned items);
    for (int unsigned k = 0; k < items; k++) begin
      if ($urandom_range(0, 99) < 12)
        add_item(make_knot(rand_coord(), rand_coord(), rand_coord()));
      else
        add_item(make_eval(rand_ratio()));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    error_count = 0;
    cycle_count = 0;
    knot_total = 0;
    curve_closed = 1'b0;
    calm_phase = 1'b0;
    in_taken = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: too few knots, extremes, ratio edges in open and then closed mode.
    add_item(make_eval(24'sd0));
    add_item(make_knot(32'sh7fffffff, 32'sh80000000, 32'sh0));
    add_item(make_knot(32'sh80000000, 32'sh7fffffff, 32'shffffffff));
    add_item(make_knot(32'sh7fffffff, 32'sh80000000, 32'sh00010000));
    add_item(make_eval(24'sd100));
    add_item(make_knot(32'sh80000000, 32'sh7fffffff, 32'sh0));
    add_item(make_eval(24'sd0));
    add_item(make_eval(24'sd32768));
    add_item(make_eval(24'sd65535));
    add_item(make_eval(24'sd65536));
    add_item(make_eval(24'sh7fffff));
    add_item(make_eval(24'sh800000));
    add_item(make_eval(-24'sd1));
    wait_drained();
    write_mode(1'b1);
    add_item(make_eval(24'sh7fffff));
    add_item(make_eval(24'sh800000));
    add_item(make_eval(-24'sd1));
    add_item(make_eval(24'sd49152));
    wait_drained();

    // Random phases across both modes; the table fills and overflows.
    for (int ph = 0; ph < 8; ph++) begin
      calm_phase = (ph == 3);
      write_mode(ph[0]);
      random_phase(220);
      wait_drained();
    end
    // Drive the store past full.
    for (int k = 0; k < 70; k++)
      add_item(make_knot(rand_coord(), rand_coord(), rand_coord()));
    random_phase(40);
    wait_drained();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
